// ===== rtl/pixel_sign_and_complex_unit_vector_defines.svh =====
// assertion macros shared by the sign and unit vector rtl
// needs i_clk and i_rst_n in the scope where a macro is used
`ifndef PIXEL_SIGN_AND_COMPLEX_UNIT_VECTOR_DEFINES_SVH
`define PIXEL_SIGN_AND_COMPLEX_UNIT_VECTOR_DEFINES_SVH

// property checked on every clock edge outside reset
`define PSUV_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// implication whose consequent is checked in the cycle after the condition
`define PSUV_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== rtl/psuv_pkg.sv =====
// types and constants for the sign and complex unit vector block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package psuv_pkg;

    localparam int unsigned FracBits = 30;
    localparam int unsigned QBits    = FracBits + 1;
    localparam int unsigned NormBits = 65;
    localparam int unsigned RemBits  = 125;
    localparam int unsigned ProdBits = 96;

    typedef enum logic [1:0] {
        FMT_UNSIGNED = 2'd0,
        FMT_SIGNED   = 2'd1,
        FMT_COMPLEX  = 2'd2,
        FMT_RESERVED = 2'd3
    } t_format;

    // one item in flight through the root search
    typedef struct packed {
        logic [NormBits-1:0] norm;
        logic [RemBits-1:0]  rem_re;
        logic [ProdBits-1:0] prod_re;
        logic [QBits-1:0]    q_re;
        logic [RemBits-1:0]  rem_im;
        logic [ProdBits-1:0] prod_im;
        logic [QBits-1:0]    q_im;
        logic                neg_re;
        logic                neg_im;
        logic                cplx;
        logic [1:0]          sign;
        logic                row_end;
    } t_item;

endpackage

`default_nettype wire

// ===== rtl/psuv_in_if.sv =====
// input channel: one pixel element per item
// uses no package
`timescale 1ns / 1ps
`default_nettype none

interface psuv_in_if;
    logic               valid;
    logic               ready;
    logic signed [32:0] sample_re;
    logic signed [31:0] sample_im;
    logic               row_end_in;

    modport source (output valid, output sample_re, output sample_im, output row_end_in,
                    input ready);
    modport sink   (input valid, input sample_re, input sample_im, input row_end_in,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/psuv_out_if.sv =====
// output channel: sign and unit vector per item
// uses no package
`timescale 1ns / 1ps
`default_nettype none

interface psuv_out_if;
    logic               valid;
    logic               ready;
    logic signed [1:0]  sign_value;
    logic signed [31:0] unit_re;
    logic signed [31:0] unit_im;
    logic               row_end_out;

    modport source (output valid, output sign_value, output unit_re, output unit_im,
                    output row_end_out, input ready);
    modport sink   (input valid, input sign_value, input unit_re, input unit_im,
                    input row_end_out, output ready);
endinterface

`default_nettype wire

// ===== rtl/psuv_root_stage.sv =====
// one bit of the restoring square root divide, both parts of the vector
// depends on psuv_pkg
`timescale 1ns / 1ps
`default_nettype none

module psuv_root_stage #(
    parameter int unsigned BIT = 0
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_en,
    input  wire                 i_valid,
    input  psuv_pkg::t_item     i_item,
    output logic                o_valid,
    output psuv_pkg::t_item     o_item
);
    import psuv_pkg::*;

    logic [127:0] w_del_re;
    logic [127:0] w_del_im;
    logic [127:0] w_nsh;
    logic         w_fit_re;
    logic         w_fit_im;
    t_item        n_item;
    logic         r_valid;
    t_item        r_item;

    // (q+2^b)^2 n - q^2 n = 2^(b+1) q n + 2^(2b) n, with q n kept in prod
    always_comb begin
        w_nsh    = {63'b0, i_item.norm} << (2 * BIT);
        w_del_re = ({32'b0, i_item.prod_re} << (BIT + 1)) + w_nsh;
        w_del_im = ({32'b0, i_item.prod_im} << (BIT + 1)) + w_nsh;
        w_fit_re = {3'b0, i_item.rem_re} >= w_del_re;
        w_fit_im = {3'b0, i_item.rem_im} >= w_del_im;
        n_item   = i_item;
        if (w_fit_re) begin
            n_item.rem_re  = i_item.rem_re - w_del_re[RemBits-1:0];
            n_item.prod_re = i_item.prod_re + ({31'b0, i_item.norm} << BIT);
            n_item.q_re    = i_item.q_re | (QBits'(1) << BIT);
        end
        if (w_fit_im) begin
            n_item.rem_im  = i_item.rem_im - w_del_im[RemBits-1:0];
            n_item.prod_im = i_item.prod_im + ({31'b0, i_item.norm} << BIT);
            n_item.q_im    = i_item.q_im | (QBits'(1) << BIT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

// ===== rtl/pixel_sign_and_complex_unit_vector.sv =====
// registered stages from input accept to output valid: abs, square, sum, 31 root bits, output
// throughput: one item per cycle; the whole pipeline stalls only while the output holds
// an item that is not taken, and input ready follows that condition
// reset: synchronous active low, clears all valid bits and sets input_format to signed
// depends on psuv_pkg, psuv_in_if, psuv_out_if, psuv_root_stage
`timescale 1ns / 1ps
`default_nettype none
`include "pixel_sign_and_complex_unit_vector_defines.svh"

module pixel_sign_and_complex_unit_vector (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire [1:0]  i_cfg_wdata,
    psuv_in_if.sink    i_in,
    psuv_out_if.source o_out
);
    import psuv_pkg::*;

    logic        w_en;
    logic [1:0]  r_format;

    // stage a: magnitudes and real-mode sign
    logic        r_a_valid;
    logic [32:0] r_a_ar;
    logic [31:0] r_a_ai;
    logic        r_a_neg_re;
    logic        r_a_neg_im;
    logic        r_a_cplx;
    logic [1:0]  r_a_sign;
    logic        r_a_row_end;
    logic [1:0]  n_a_sign;
    logic        n_a_cplx;

    // stage b: squares
    logic        r_b_valid;
    logic [64:0] r_b_sq_re;
    logic [62:0] r_b_sq_im;
    logic        r_b_neg_re;
    logic        r_b_neg_im;
    logic        r_b_cplx;
    logic [1:0]  r_b_sign;
    logic        r_b_row_end;

    // stage c: norm and initial remainders
    logic        r_c_valid;
    t_item       r_c_item;
    t_item       n_c_item;

    logic        w_valid [0:QBits];
    t_item       w_item  [0:QBits];

    logic               r_o_valid;
    logic signed [1:0]  r_o_sign;
    logic signed [31:0] r_o_re;
    logic signed [31:0] r_o_im;
    logic               r_o_row_end;

    assign w_en       = !r_o_valid || o_out.ready;
    assign i_in.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= FMT_SIGNED;
        end else if (i_cfg_we) begin
            r_format <= i_cfg_wdata;
        end
    end

    always_comb begin
        n_a_sign = 2'b00;
        n_a_cplx = 1'b0;
        case (t_format'(r_format))
            FMT_UNSIGNED: begin
                n_a_sign = (|i_in.sample_re) ? 2'b01 : 2'b00;
            end
            FMT_COMPLEX: begin
                n_a_cplx = (|i_in.sample_re) || (|i_in.sample_im);
            end
            default: begin
                if (i_in.sample_re[32]) begin
                    n_a_sign = 2'b11;
                end else if (|i_in.sample_re) begin
                    n_a_sign = 2'b01;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (w_en) begin
            r_a_valid <= i_in.valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_ar      <= i_in.sample_re[32] ? 33'(-i_in.sample_re) : i_in.sample_re;
            r_a_ai      <= i_in.sample_im[31] ? 32'(-i_in.sample_im) : i_in.sample_im;
            r_a_neg_re  <= i_in.sample_re[32];
            r_a_neg_im  <= i_in.sample_im[31];
            r_a_cplx    <= n_a_cplx;
            r_a_sign    <= n_a_sign;
            r_a_row_end <= i_in.row_end_in;

            r_b_sq_re   <= 65'(r_a_ar * r_a_ar);
            r_b_sq_im   <= 63'(r_a_ai * r_a_ai);
            r_b_neg_re  <= r_a_neg_re;
            r_b_neg_im  <= r_a_neg_im;
            r_b_cplx    <= r_a_cplx;
            r_b_sign    <= r_a_sign;
            r_b_row_end <= r_a_row_end;

            r_c_item    <= n_c_item;
        end
    end

    always_comb begin
        n_c_item         = '0;
        n_c_item.norm    = r_b_sq_re + {2'b0, r_b_sq_im};
        n_c_item.rem_re  = {r_b_sq_re, 60'b0};
        n_c_item.rem_im  = {2'b0, r_b_sq_im, 60'b0};
        n_c_item.neg_re  = r_b_neg_re;
        n_c_item.neg_im  = r_b_neg_im;
        n_c_item.cplx    = r_b_cplx;
        n_c_item.sign    = r_b_sign;
        n_c_item.row_end = r_b_row_end;
    end

    assign w_valid[0] = r_c_valid;
    assign w_item[0]  = r_c_item;

    for (genvar k = 0; k < QBits; k++) begin : g_root
        psuv_root_stage #(
            .BIT (QBits - 1 - k)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[k]),
            .i_item  (w_item[k]),
            .o_valid (w_valid[k+1]),
            .o_item  (w_item[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_en) begin
            r_o_valid <= w_valid[QBits];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_sign    <= w_item[QBits].sign;
            r_o_row_end <= w_item[QBits].row_end;
            if (w_item[QBits].cplx) begin
                r_o_re <= w_item[QBits].neg_re ? -{1'b0, w_item[QBits].q_re}
                                                 : {1'b0, w_item[QBits].q_re};
                r_o_im <= w_item[QBits].neg_im ? -{1'b0, w_item[QBits].q_im}
                                                 : {1'b0, w_item[QBits].q_im};
            end else begin
                r_o_re <= '0;
                r_o_im <= '0;
            end
        end
    end

    assign o_out.valid       = r_o_valid;
    assign o_out.sign_value  = r_o_sign;
    assign o_out.unit_re     = r_o_re;
    assign o_out.unit_im     = r_o_im;
    assign o_out.row_end_out = r_o_row_end;

    `PSUV_ASSERT(a_real_no_vector,
        !(o_out.valid && o_out.sign_value != 2'sb00) ||
        (o_out.unit_re == 32'sd0 && o_out.unit_im == 32'sd0),
        "unit vector nonzero with a real sign")
    `PSUV_ASSERT(a_sign_code, !o_out.valid || o_out.sign_value != 2'sb10,
        "invalid sign code")
    `PSUV_ASSERT(a_re_range, !o_out.valid ||
        (o_out.unit_re <= 32'sd1073741824 && o_out.unit_re >= -32'sd1073741824),
        "unit_re out of range")
    `PSUV_ASSERT_NEXT(a_stall_hold, r_o_valid && !o_out.ready,
        r_o_valid && $stable(r_o_re) && $stable(w_valid[QBits]),
        "pipeline moved during output stall")

endmodule

`default_nettype wire
